// File: src/bsm_pkg.sv
// Package with payload types, operation and status codes for the stack machine unit.
package bsm_pkg;

  // Program size fixes the width of the program counter and the statement fields.
  localparam int PROGRAM_SIZE = 4096;

  typedef enum logic [4:0] {
    OP_INVALID = 5'd0,  OP_ADD = 5'd1,   OP_SUB = 5'd2,   OP_MUL = 5'd3,
    OP_DIV = 5'd4,      OP_POW = 5'd5,   OP_MOD = 5'd6,   OP_LT = 5'd7,
    OP_GT = 5'd8,       OP_LE = 5'd9,    OP_GE = 5'd10,   OP_EQ = 5'd11,
    OP_NE = 5'd12,      OP_SQRT = 5'd13, OP_NOT = 5'd14,  OP_PUSH = 5'd15,
    OP_DUP = 5'd16,     OP_PUT = 5'd17,  OP_TAKE = 5'd18, OP_IN = 5'd19,
    OP_OUT = 5'd20,     OP_OUTC = 5'd21, OP_END = 5'd22,  OP_MARK = 5'd23,
    OP_GOTO = 5'd24,    OP_VISIT = 5'd25, OP_BACK = 5'd26
  } op_t;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_FINISHED = 4'd1;
  localparam logic [3:0] ST_INVALID  = 4'd2;
  localparam logic [3:0] ST_UNDER    = 4'd3;
  localparam logic [3:0] ST_OVER     = 4'd4;
  localparam logic [3:0] ST_DIVZERO  = 4'd5;
  localparam logic [3:0] ST_BADREG   = 4'd6;
  localparam logic [3:0] ST_DOMAIN   = 4'd7;
  localparam logic [3:0] ST_RETEMPTY = 4'd8;

  typedef struct packed {
    logic [4:0]        operation;
    logic signed [7:0] immediate;
    logic [11:0]       jump_target;
    logic [7:0]        input_byte;
  } in_item_t;

  typedef struct packed {
    logic [11:0]       next_index;
    logic              out_valid;
    logic              out_is_char;
    logic signed [7:0] out_byte;
    logic [3:0]        status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_ITER, S_DONE
  } state_t;

endpackage

// File: src/byte_stack_machine_execute.sv
// Stack machine execution unit: one decoded instruction per request.
//
//   channel | ports            | direction | payload
//   input   | in_valid/in_ready | in       | bsm_pkg::in_item_t
//   result  | out_valid/out_ready | out    | bsm_pkg::out_item_t
//
// A simple instruction offers its result once the request is accepted, the
// single data stack read port has read the top and then the entry below it,
// and it has executed; no new request is taken until the last one is through.
// Divide and modulo add an iteration (eight quotient bits and a write-back),
// square root adds one (two radicand bits a step), and power adds one multiply
// step per unit of the exponent and a write-back. Reset (rst_n low, synchronous) clears depths,
// the register file and the program counter. A result waits in the output
// register until taken; the next request is accepted in the cycle it leaves.
module byte_stack_machine_execute #(
  parameter int DATA_STACK_DEPTH   = 256,
  parameter int RETURN_STACK_DEPTH = 64,
  parameter int REGISTER_COUNT     = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bsm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bsm_pkg::out_item_t out_data
);
  localparam int DAW = (DATA_STACK_DEPTH > 1) ? $clog2(DATA_STACK_DEPTH) : 1;
  localparam int DDW = $clog2(DATA_STACK_DEPTH + 1);
  localparam int RAW = (RETURN_STACK_DEPTH > 1) ? $clog2(RETURN_STACK_DEPTH) : 1;
  localparam int RDW = $clog2(RETURN_STACK_DEPTH + 1);
  localparam int GAW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam int PCW = $clog2(bsm_pkg::PROGRAM_SIZE);

  // Memories and architectural state.
  logic [7:0]     dmem [DATA_STACK_DEPTH];
  logic [PCW-1:0] rmem [RETURN_STACK_DEPTH];
  logic [7:0]     regs_r [REGISTER_COUNT];
  logic [DDW-1:0] ddepth_r;
  logic [RDW-1:0] rdepth_r;
  logic [PCW-1:0] pc_r;

  bsm_pkg::state_t   state_r, state_nxt;
  bsm_pkg::in_item_t req_r;
  bsm_pkg::out_item_t res_r;
  logic [1:0] phase_r;            // read phase counter in S_READ
  logic [7:0] top_r, sec_r;       // top and second data entries
  logic [PCW-1:0] ret_r;          // return stack top
  logic [7:0] dq;                 // data memory read data
  logic [PCW-1:0] rq;             // return memory read data
  logic [DAW-1:0] draddr;

  // Iteration registers for div, mod, sqrt and pow.
  logic [7:0]  it_cnt_r;
  logic [15:0] it_rem_r;          // remainder (div) or square-root remainder
  logic [7:0]  it_quo_r;          // quotient or root or power accumulator
  logic [7:0]  it_div_r;          // divisor magnitude or power base
  logic [7:0]  it_src_r;          // dividend magnitude or radicand

  // Execute decision.
  logic [3:0] st;
  logic       dwe, rwe, gwe, iter_go;
  logic [DAW-1:0] dwaddr;
  logic [7:0]  dwdata;
  logic [DDW-1:0] dd_nxt;
  logic [RDW-1:0] rd_nxt;
  logic [PCW-1:0] nxt;
  logic       ov, ochar;
  logic [7:0] obyte;
  logic signed [7:0] l, r;
  logic [7:0] la, ra;
  logic       reg_ok;
  logic [GAW-1:0] gidx;

  assign l  = sec_r;
  assign r  = top_r;
  assign la = l[7] ? 8'(-l) : 8'(l);
  assign ra = r[7] ? 8'(-r) : 8'(r);
  assign reg_ok = (req_r.immediate >= 0) && (int'(req_r.immediate) < REGISTER_COUNT);
  assign gidx = GAW'(req_r.immediate[6:0]);

  assign in_ready = (state_r == bsm_pkg::S_IDLE) ||
                    (state_r == bsm_pkg::S_DONE && out_ready);
  assign out_valid = (state_r == bsm_pkg::S_DONE);
  assign out_data  = res_r;

  // Read address: phase 0 reads the top, phase 1 the entry below it.
  always_comb begin
    draddr = DAW'(ddepth_r - DDW'(1));
    if (phase_r != 2'd0) draddr = DAW'(ddepth_r - DDW'(2));
  end

  // Synchronous memory reads and writes.
  always_ff @(posedge clk) begin
    dq <= dmem[draddr];
    rq <= rmem[RAW'(rdepth_r - RDW'(1))];
    if (dwe) dmem[dwaddr] <= dwdata;
    if (rwe) rmem[RAW'(rdepth_r)] <= pc_r;
  end

  // Execute stage: compute status and state updates for one instruction.
  always_comb begin
    logic [7:0] v;
    logic [PCW-1:0] pc1;
    v = 8'd0;
    pc1 = PCW'(pc_r + PCW'(1));
    st = bsm_pkg::ST_OK; dwe = 1'b0; rwe = 1'b0; gwe = 1'b0; iter_go = 1'b0;
    dwaddr = DAW'(ddepth_r - DDW'(1)); dwdata = 8'd0;
    dd_nxt = ddepth_r; rd_nxt = rdepth_r; nxt = pc1;
    ov = 1'b0; ochar = 1'b0; obyte = 8'd0;
    case (req_r.operation)
      bsm_pkg::OP_ADD, bsm_pkg::OP_SUB, bsm_pkg::OP_MUL, bsm_pkg::OP_DIV,
      bsm_pkg::OP_POW, bsm_pkg::OP_MOD, bsm_pkg::OP_LT, bsm_pkg::OP_GT,
      bsm_pkg::OP_LE, bsm_pkg::OP_GE, bsm_pkg::OP_EQ, bsm_pkg::OP_NE: begin
        if (ddepth_r < DDW'(2)) st = bsm_pkg::ST_UNDER;
        else begin
          dwaddr = DAW'(ddepth_r - DDW'(2));
          dd_nxt = DDW'(ddepth_r - DDW'(1));
          case (req_r.operation)
            bsm_pkg::OP_ADD: v = 8'(l + r);
            bsm_pkg::OP_SUB: v = 8'(l - r);
            bsm_pkg::OP_MUL: v = 8'(l * r);
            bsm_pkg::OP_LT:  v = {7'd0, l < r};
            bsm_pkg::OP_GT:  v = {7'd0, l > r};
            bsm_pkg::OP_LE:  v = {7'd0, l <= r};
            bsm_pkg::OP_GE:  v = {7'd0, l >= r};
            bsm_pkg::OP_EQ:  v = {7'd0, l == r};
            bsm_pkg::OP_NE:  v = {7'd0, l != r};
            bsm_pkg::OP_DIV, bsm_pkg::OP_MOD: begin
              if (r == 0) st = bsm_pkg::ST_DIVZERO;
              else iter_go = 1'b1;
            end
            default: begin
              // Power: negative exponents are resolved here.
              if (!r[7]) iter_go = 1'b1;
              else if (l == 0) st = bsm_pkg::ST_DIVZERO;
              else if (l == 1) v = 8'd1;
              else if (l == -1) v = r[0] ? 8'hFF : 8'd1;
              else v = 8'd0;
            end
          endcase
          dwdata = v;
          dwe = (st == bsm_pkg::ST_OK) && !iter_go;
        end
      end
      bsm_pkg::OP_SQRT, bsm_pkg::OP_NOT: begin
        if (ddepth_r < DDW'(1)) st = bsm_pkg::ST_UNDER;
        else if (req_r.operation == bsm_pkg::OP_SQRT) begin
          if (r < 0) st = bsm_pkg::ST_DOMAIN;
          else iter_go = 1'b1;
        end else begin
          dwe = 1'b1; dwdata = {7'd0, r == 0};
        end
      end
      bsm_pkg::OP_PUSH, bsm_pkg::OP_DUP, bsm_pkg::OP_TAKE, bsm_pkg::OP_IN: begin
        if (req_r.operation == bsm_pkg::OP_TAKE && !reg_ok) st = bsm_pkg::ST_BADREG;
        else if (req_r.operation == bsm_pkg::OP_DUP && ddepth_r < DDW'(1))
          st = bsm_pkg::ST_UNDER;
        else if (int'(ddepth_r) >= DATA_STACK_DEPTH) st = bsm_pkg::ST_OVER;
        else begin
          dwe = 1'b1; dwaddr = DAW'(ddepth_r); dd_nxt = DDW'(ddepth_r + DDW'(1));
          case (req_r.operation)
            bsm_pkg::OP_PUSH: dwdata = req_r.immediate;
            bsm_pkg::OP_DUP:  dwdata = top_r;
            bsm_pkg::OP_TAKE: dwdata = regs_r[gidx];
            default:          dwdata = req_r.input_byte;
          endcase
        end
      end
      bsm_pkg::OP_PUT: begin
        if (!reg_ok) st = bsm_pkg::ST_BADREG;
        else if (ddepth_r < DDW'(1)) st = bsm_pkg::ST_UNDER;
        else begin gwe = 1'b1; dd_nxt = DDW'(ddepth_r - DDW'(1)); end
      end
      bsm_pkg::OP_OUT, bsm_pkg::OP_OUTC: begin
        if (ddepth_r < DDW'(1)) st = bsm_pkg::ST_UNDER;
        else begin
          dd_nxt = DDW'(ddepth_r - DDW'(1)); ov = 1'b1; obyte = top_r;
          ochar = (req_r.operation == bsm_pkg::OP_OUTC);
        end
      end
      bsm_pkg::OP_END:  st = bsm_pkg::ST_FINISHED;
      bsm_pkg::OP_MARK: ;
      bsm_pkg::OP_GOTO, bsm_pkg::OP_VISIT: begin
        if (req_r.operation == bsm_pkg::OP_VISIT &&
            int'(rdepth_r) >= RETURN_STACK_DEPTH) st = bsm_pkg::ST_OVER;
        else begin
          if (req_r.operation == bsm_pkg::OP_VISIT) begin
            rwe = 1'b1; rd_nxt = RDW'(rdepth_r + RDW'(1));
          end
          nxt = PCW'(PCW'(req_r.jump_target) + PCW'(1));
        end
      end
      bsm_pkg::OP_BACK: begin
        if (rdepth_r == RDW'(0)) st = bsm_pkg::ST_RETEMPTY;
        else begin rd_nxt = RDW'(rdepth_r - RDW'(1)); nxt = PCW'(ret_r + PCW'(1)); end
      end
      default: st = bsm_pkg::ST_INVALID;
    endcase
    if (st != bsm_pkg::ST_OK) begin
      dwe = 1'b0; rwe = 1'b0; gwe = 1'b0; iter_go = 1'b0;
      dd_nxt = ddepth_r; rd_nxt = rdepth_r; nxt = pc_r; ov = 1'b0;
      ochar = 1'b0; obyte = 8'd0;
    end
    if (state_r != bsm_pkg::S_EXEC) begin
      dwe = 1'b0; rwe = 1'b0; gwe = 1'b0; iter_go = 1'b0;
    end
    // The iteration unit writes its result back on its last step. The depth
    // has already been updated, so the target is the new top in every case.
    if (state_r == bsm_pkg::S_ITER && it_cnt_r == 8'd0) begin
      dwe = 1'b1;
      dwaddr = DAW'(ddepth_r - DDW'(1));
      case (req_r.operation)
        bsm_pkg::OP_DIV: dwdata = (l[7] ^ r[7]) ? 8'(-it_quo_r) : it_quo_r;
        bsm_pkg::OP_MOD: dwdata = l[7] ? 8'(-it_rem_r[7:0]) : it_rem_r[7:0];
        default:         dwdata = it_quo_r;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsm_pkg::S_IDLE: if (in_valid) state_nxt = bsm_pkg::S_READ;
      bsm_pkg::S_READ: if (phase_r == 2'd2) state_nxt = bsm_pkg::S_EXEC;
      bsm_pkg::S_EXEC: state_nxt = iter_go ? bsm_pkg::S_ITER : bsm_pkg::S_DONE;
      bsm_pkg::S_ITER: if (it_cnt_r == 8'd0) state_nxt = bsm_pkg::S_DONE;
      bsm_pkg::S_DONE: begin
        if (out_ready) state_nxt = in_valid ? bsm_pkg::S_READ : bsm_pkg::S_IDLE;
      end
      default: state_nxt = bsm_pkg::S_IDLE;
    endcase
  end

  // Control registers and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bsm_pkg::S_IDLE;
      ddepth_r <= '0;
      rdepth_r <= '0;
      pc_r     <= '0;
      phase_r  <= 2'd0;
      for (int i = 0; i < REGISTER_COUNT; i++) regs_r[i] <= 8'd0;
    end else begin
      state_r <= state_nxt;
      if (in_valid && in_ready) phase_r <= 2'd0;
      else if (state_r == bsm_pkg::S_READ) phase_r <= 2'(phase_r + 2'd1);
      if (state_r == bsm_pkg::S_EXEC) begin
        ddepth_r <= dd_nxt;
        rdepth_r <= rd_nxt;
        pc_r     <= nxt;
        if (gwe) regs_r[gidx] <= top_r;
      end
    end
  end

  // Payload registers: request, operands, iteration and result.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) req_r <= in_data;
    if (state_r == bsm_pkg::S_READ && phase_r == 2'd1) begin
      top_r <= dq;
      ret_r <= rq;
    end
    if (state_r == bsm_pkg::S_READ && phase_r == 2'd2) sec_r <= dq;
    if (state_r == bsm_pkg::S_EXEC) begin
      res_r.next_index  <= 12'(nxt);
      res_r.out_valid   <= ov;
      res_r.out_is_char <= ochar;
      res_r.out_byte    <= obyte;
      res_r.status      <= st;
      it_rem_r <= 16'd0;
      it_div_r <= (req_r.operation == bsm_pkg::OP_POW) ? sec_r : ra;
      it_src_r <= (req_r.operation == bsm_pkg::OP_SQRT) ? top_r : la;
      it_quo_r <= (req_r.operation == bsm_pkg::OP_POW) ? 8'd1 : 8'd0;
      if (req_r.operation == bsm_pkg::OP_POW) it_cnt_r <= top_r;
      else if (req_r.operation == bsm_pkg::OP_SQRT) it_cnt_r <= 8'd4;
      else it_cnt_r <= 8'd8;
    end
    if (state_r == bsm_pkg::S_ITER && it_cnt_r != 8'd0) begin
      it_cnt_r <= 8'(it_cnt_r - 8'd1);
      case (req_r.operation)
        bsm_pkg::OP_POW: it_quo_r <= 8'(it_quo_r * it_div_r);
        bsm_pkg::OP_SQRT: begin
          // Two radicand bits per step; trial is 4*root+1.
          logic [15:0] rem2, trial;
          rem2  = {it_rem_r[13:0], it_src_r[7:6]};
          trial = {6'd0, it_quo_r, 2'b01};
          it_src_r <= {it_src_r[5:0], 2'b00};
          if (rem2 >= trial) begin
            it_rem_r <= 16'(rem2 - trial);
            it_quo_r <= {it_quo_r[6:0], 1'b1};
          end else begin
            it_rem_r <= rem2;
            it_quo_r <= {it_quo_r[6:0], 1'b0};
          end
        end
        default: begin
          // Restoring division, one quotient bit per step.
          logic [15:0] rem2;
          rem2 = {it_rem_r[14:0], it_src_r[7]};
          it_src_r <= {it_src_r[6:0], 1'b0};
          if (rem2 >= {8'd0, it_div_r}) begin
            it_rem_r <= 16'(rem2 - {8'd0, it_div_r});
            it_quo_r <= {it_quo_r[6:0], 1'b1};
          end else begin
            it_rem_r <= rem2;
            it_quo_r <= {it_quo_r[6:0], 1'b0};
          end
        end
      endcase
    end
  end

  // A result is only offered once it has been computed.
  a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == bsm_pkg::S_EXEC ||
                          $past(state_r) == bsm_pkg::S_ITER))
    else $error("result offered without execution");

  // Errors leave the program counter unchanged.
  a_err_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bsm_pkg::S_EXEC && st != bsm_pkg::ST_OK) |=> $stable(pc_r))
    else $error("program counter moved on error");

  // Depth never exceeds the stack size.
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    int'(ddepth_r) <= DATA_STACK_DEPTH && int'(rdepth_r) <= RETURN_STACK_DEPTH)
    else $error("stack depth out of range");

endmodule

// File: tb/byte_stack_machine_execute_test.sv
// Testbench for the stack machine execution unit: directed and random instruction streams.
module byte_stack_machine_execute_test;

  localparam int DSTACK = 256;
  localparam int RSTACK = 64;
  localparam int NREG = 8;
  localparam int PSIZE = bsm_pkg::PROGRAM_SIZE;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [4:0] OP_CODE_TOP = 5'd31;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bsm_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bsm_pkg::out_item_t out_data;

  byte_stack_machine_execute uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always #4 clk = ~clk;

  // Predicted machine state.
  logic [7:0] m_dstack [DSTACK];
  int m_ddepth;
  logic [11:0] m_rstack [RSTACK];
  int m_rdepth;
  logic [7:0] m_regs [NREG];
  logic [11:0] m_pc;

  bsm_pkg::in_item_t pending_requests [$];
  bsm_pkg::out_item_t expected_results [$];
  int errors = 0;
  int accepted_requests = 0;
  int checked_results = 0;
  bit quiet_phase = 1'b0;
  bit hold_sender = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s got %0d expected %0d",
      checked_results, what, got, want);
    errors++;
  endtask

  function automatic logic [7:0] int_pow(input int b, input int e);
    logic [7:0] acc;
    acc = 8'd1;
    for (int k = 0; k < e; k++) acc = acc * b[7:0];
    return acc;
  endfunction

  function automatic int isqrt(input int v);
    int s;
    s = 0;
    while ((s + 1) * (s + 1) <= v) s++;
    return s;
  endfunction

  // Executes one instruction on the predicted state and returns its result.
  function automatic bsm_pkg::out_item_t execute_instruction(input bsm_pkg::in_item_t it);
    bsm_pkg::out_item_t r;
    logic [3:0] st;
    logic [11:0] nxt;
    int l, rr, v, imm;
    logic [7:0] res, val;
    bsm_pkg::op_t op;
    r = '0;
    st = bsm_pkg::ST_OK;
    nxt = 12'((m_pc + 1) % PSIZE);
    imm = it.immediate;
    op = bsm_pkg::op_t'(it.operation);
    res = '0;
    val = '0;
    if (it.operation >= bsm_pkg::OP_ADD && it.operation <= bsm_pkg::OP_NE) begin
      if (m_ddepth < 2) st = bsm_pkg::ST_UNDER;
      else begin
        rr = $signed(m_dstack[m_ddepth-1]);
        l = $signed(m_dstack[m_ddepth-2]);
        case (op)
          bsm_pkg::OP_ADD: res = 8'(l + rr);
          bsm_pkg::OP_SUB: res = 8'(l - rr);
          bsm_pkg::OP_MUL: res = 8'(l * rr);
          bsm_pkg::OP_DIV: if (rr == 0) st = bsm_pkg::ST_DIVZERO; else res = 8'(l / rr);
          bsm_pkg::OP_MOD: if (rr == 0) st = bsm_pkg::ST_DIVZERO; else res = 8'(l % rr);
          bsm_pkg::OP_POW: begin
            if (rr >= 0) res = int_pow(l, rr);
            else if (l == 0) st = bsm_pkg::ST_DIVZERO;
            else if (l == 1) res = 8'd1;
            else if (l == -1) res = rr[0] ? 8'hFF : 8'd1;
            else res = 8'd0;
          end
          bsm_pkg::OP_LT: res = {7'd0, l < rr};
          bsm_pkg::OP_GT: res = {7'd0, l > rr};
          bsm_pkg::OP_LE: res = {7'd0, l <= rr};
          bsm_pkg::OP_GE: res = {7'd0, l >= rr};
          bsm_pkg::OP_EQ: res = {7'd0, l == rr};
          default: res = {7'd0, l != rr};
        endcase
        if (st == bsm_pkg::ST_OK) begin
          m_ddepth--;
          m_dstack[m_ddepth-1] = res;
        end
      end
    end else if (op == bsm_pkg::OP_SQRT || op == bsm_pkg::OP_NOT) begin
      if (m_ddepth < 1) st = bsm_pkg::ST_UNDER;
      else begin
        v = $signed(m_dstack[m_ddepth-1]);
        if (op == bsm_pkg::OP_SQRT) begin
          if (v < 0) st = bsm_pkg::ST_DOMAIN;
          else m_dstack[m_ddepth-1] = 8'(isqrt(v));
        end else m_dstack[m_ddepth-1] = {7'd0, v == 0};
      end
    end else if (op == bsm_pkg::OP_PUSH || op == bsm_pkg::OP_DUP ||
                 op == bsm_pkg::OP_TAKE || op == bsm_pkg::OP_IN) begin
      if (op == bsm_pkg::OP_TAKE && (imm < 0 || imm >= NREG)) st = bsm_pkg::ST_BADREG;
      else if (op == bsm_pkg::OP_DUP && m_ddepth < 1) st = bsm_pkg::ST_UNDER;
      else if (m_ddepth >= DSTACK) st = bsm_pkg::ST_OVER;
      if (st == bsm_pkg::ST_OK) begin
        if (op == bsm_pkg::OP_PUSH) val = it.immediate;
        else if (op == bsm_pkg::OP_DUP) val = m_dstack[m_ddepth-1];
        else if (op == bsm_pkg::OP_TAKE) val = m_regs[imm];
        else val = it.input_byte;
        m_dstack[m_ddepth] = val;
        m_ddepth++;
      end
    end else if (op == bsm_pkg::OP_PUT) begin
      if (imm < 0 || imm >= NREG) st = bsm_pkg::ST_BADREG;
      else if (m_ddepth < 1) st = bsm_pkg::ST_UNDER;
      else begin
        m_ddepth--;
        m_regs[imm] = m_dstack[m_ddepth];
      end
    end else if (op == bsm_pkg::OP_OUT || op == bsm_pkg::OP_OUTC) begin
      if (m_ddepth < 1) st = bsm_pkg::ST_UNDER;
      else begin
        m_ddepth--;
        r.out_byte = m_dstack[m_ddepth];
        r.out_valid = 1'b1;
        r.out_is_char = (op == bsm_pkg::OP_OUTC);
      end
    end else if (op == bsm_pkg::OP_END) st = bsm_pkg::ST_FINISHED;
    else if (op == bsm_pkg::OP_MARK) begin
      // Marks do nothing but advance.
    end else if (op == bsm_pkg::OP_GOTO || op == bsm_pkg::OP_VISIT) begin
      if (op == bsm_pkg::OP_VISIT && m_rdepth >= RSTACK) st = bsm_pkg::ST_OVER;
      else begin
        if (op == bsm_pkg::OP_VISIT) begin
          m_rstack[m_rdepth] = m_pc;
          m_rdepth++;
        end
        nxt = 12'((it.jump_target + 1) % PSIZE);
      end
    end else if (op == bsm_pkg::OP_BACK) begin
      if (m_rdepth == 0) st = bsm_pkg::ST_RETEMPTY;
      else begin
        m_rdepth--;
        nxt = 12'((m_rstack[m_rdepth] + 1) % PSIZE);
      end
    end else st = bsm_pkg::ST_INVALID;
    if (st != bsm_pkg::ST_OK) begin
      nxt = m_pc;
      r.out_valid = 1'b0;
      r.out_is_char = 1'b0;
      r.out_byte = '0;
    end
    m_pc = nxt;
    r.next_index = nxt;
    r.status = st;
    return r;
  endfunction

  function automatic bsm_pkg::in_item_t make_req(input bsm_pkg::op_t op, input int imm = 0,
                                                 input int tgt = 0, input int b = 0);
    bsm_pkg::in_item_t it;
    it.operation = op;
    it.immediate = 8'(imm);
    it.jump_target = 12'(tgt);
    it.input_byte = 8'(b);
    return it;
  endfunction

  // Sender: issues queued requests with random idle bursts.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(execute_instruction(in_data));
        accepted_requests++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0 && !hold_sender) begin
          in_data <= pending_requests.pop_front();
          in_valid <= 1'b1;
          if (!quiet_phase && $urandom_range(0, 9) == 0)
            send_gap <= int'($urandom_range(1, 16));
        end else in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, checks each result against the prediction.
  int recv_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result status", out_data.status, -1);
        end else begin
          bsm_pkg::out_item_t w;
          w = expected_results.pop_front();
          if (out_data.next_index !== w.next_index)
            report_mismatch("next_index", out_data.next_index, w.next_index);
          if (out_data.out_valid !== w.out_valid)
            report_mismatch("out_valid", out_data.out_valid, w.out_valid);
          if (out_data.out_is_char !== w.out_is_char)
            report_mismatch("out_is_char", out_data.out_is_char, w.out_is_char);
          if (out_data.out_byte !== w.out_byte)
            report_mismatch("out_byte", out_data.out_byte, w.out_byte);
          if (out_data.status !== w.status)
            report_mismatch("status", out_data.status, w.status);
        end
        checked_results++;
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        recv_gap <= int'($urandom_range(1, 16));
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any handshake.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no request or result moved for %0d cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // Random instruction with a fixed bias toward pushes and inputs that grow the stack.
  function automatic bsm_pkg::in_item_t random_req();
    bsm_pkg::in_item_t it;
    int sel;
    it.operation = 5'($urandom_range(0, 31));
    it.immediate = 8'($urandom);
    it.jump_target = 12'($urandom);
    it.input_byte = 8'($urandom);
    sel = int'($urandom_range(0, 99));
    if (sel < 30) begin
      it.operation = ($urandom_range(0, 1)) ? bsm_pkg::OP_PUSH : bsm_pkg::OP_IN;
      if ($urandom_range(0, 3) == 0) it.immediate = 8'(int'($urandom_range(0, 4)) - 2);
    end else if (sel < 75) begin
      it.operation = 5'($urandom_range(bsm_pkg::OP_ADD, bsm_pkg::OP_OUTC));
      if (it.operation == bsm_pkg::OP_PUT || it.operation == bsm_pkg::OP_TAKE)
        it.immediate = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                   : 8'($urandom_range(0, NREG - 1));
    end else if (sel < 90) begin
      it.operation = 5'($urandom_range(bsm_pkg::OP_GOTO, bsm_pkg::OP_BACK));
    end
    return it;
  endfunction

  initial begin
    m_ddepth = 0;
    m_rdepth = 0;
    m_pc = '0;
    for (int i = 0; i < NREG; i++) m_regs[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: errors on an empty machine, field extremes, corner arithmetic.
    pending_requests.push_back(make_req(bsm_pkg::OP_ADD));
    pending_requests.push_back(make_req(bsm_pkg::OP_BACK));
    pending_requests.push_back(make_req(bsm_pkg::OP_INVALID));
    pending_requests.push_back(make_req(bsm_pkg::op_t'(OP_CODE_TOP)));
    pending_requests.push_back(make_req(bsm_pkg::OP_TAKE, -1));
    pending_requests.push_back(make_req(bsm_pkg::OP_PUT, NREG));
    pending_requests.push_back(make_req(bsm_pkg::OP_PUSH, -128));
    pending_requests.push_back(make_req(bsm_pkg::OP_PUSH, -1));
    pending_requests.push_back(make_req(bsm_pkg::OP_DIV));
    pending_requests.push_back(make_req(bsm_pkg::OP_PUSH, -128));
    pending_requests.push_back(make_req(bsm_pkg::OP_PUSH, -1));
    pending_requests.push_back(make_req(bsm_pkg::OP_MOD));
    pending_requests.push_back(make_req(bsm_pkg::OP_PUSH, 0));
    pending_requests.push_back(make_req(bsm_pkg::OP_DIV));
    pending_requests.push_back(make_req(bsm_pkg::OP_POW));
    pending_requests.push_back(make_req(bsm_pkg::OP_IN, 0, 0, 255));
    pending_requests.push_back(make_req(bsm_pkg::OP_SQRT));
    pending_requests.push_back(make_req(bsm_pkg::OP_PUSH, 127));
    pending_requests.push_back(make_req(bsm_pkg::OP_SQRT));
    pending_requests.push_back(make_req(bsm_pkg::OP_PUT, NREG - 1));
    pending_requests.push_back(make_req(bsm_pkg::OP_TAKE, NREG - 1));
    pending_requests.push_back(make_req(bsm_pkg::OP_OUTC));
    pending_requests.push_back(make_req(bsm_pkg::OP_VISIT, 0, 4095));
    pending_requests.push_back(make_req(bsm_pkg::OP_BACK));
    pending_requests.push_back(make_req(bsm_pkg::OP_END));

    // Pause the sender until every directed result is back.
    wait (pending_requests.size() == 0);
    hold_sender = 1'b1;
    wait (expected_results.size() == 0 && !in_valid);
    hold_sender = 1'b0;

    // Fill the return stack past its limit and the data stack past its limit.
    for (int i = 0; i <= RSTACK; i++)
      pending_requests.push_back(make_req(bsm_pkg::OP_VISIT, 0, int'($urandom)));
    for (int i = 0; i < 4; i++) pending_requests.push_back(make_req(bsm_pkg::OP_BACK));
    for (int i = 0; i <= DSTACK; i++)
      pending_requests.push_back(make_req(bsm_pkg::OP_PUSH, int'($urandom)));
    for (int i = 0; i < 16; i++) pending_requests.push_back(make_req(bsm_pkg::OP_OUT));

    for (int i = 0; i < 180; i++) begin
      if (i == 140) begin
        wait (pending_requests.size() == 0);
        quiet_phase = 1'b1;
      end
      pending_requests.push_back(random_req());
    end
    wait (pending_requests.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    $display("Ran %0d instructions, checked %0d results.", accepted_requests, checked_results);
    $display("Covered every operation, stack limits, register bounds and arithmetic corners.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
